// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: src/dfdu_pkg.sv
package dfdu_pkg;

   localparam int MAX_WORDS_PER_ROW = 16;
   localparam int MAX_ROWS          = 64;
   localparam int STORE_DEPTH       = MAX_ROWS * MAX_WORDS_PER_ROW;

   localparam int WORD_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_WORDS_PER_ROW);
   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int RC_W     = 7;
   localparam int WPR_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [RC_W-1:0]  RC_MAX    = RC_W'(MAX_ROWS);
   localparam logic [WPR_W-1:0] WPR_MAX   = WPR_W'(MAX_WORDS_PER_ROW);
   localparam logic [RC_W-1:0]  RC_RESET  = 7'd64;
   localparam logic [WPR_W-1:0] WPR_RESET = 5'd8;

   localparam logic [BYTE_W-1:0] CMD_ADDR = 8'h80;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORDS_PER_ROW = 2'd1;

   // One queue word: two bytes, high first.
   typedef struct packed {
      logic              is_word;
      logic              last;
      logic [WORD_W-1:0] word;
   } entry_type;

   function automatic logic [WORD_W-1:0] rev16(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] r;
      for (int i = 0; i < WORD_W; i++) begin
         r[i] = v[WORD_W-1-i];
      end
      return r;
   endfunction

endpackage

// File: src/dfdu_ram.sv
module dfdu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/dfdu_front.sv
module dfdu_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [dfdu_pkg::WORD_W-1:0]       pixel_word,
   input  logic                              frame_start,
   input  logic [dfdu_pkg::RC_W-1:0]         row_count,
   input  logic [dfdu_pkg::WPR_W-1:0]        words_per_row,
   input  logic                              q_full,
   output logic                              q_push,
   output dfdu_pkg::entry_type               q_entry
);

   typedef enum logic [3:0] {
      ST_CLEAR   = 4'b0001,
      ST_IDLE    = 4'b0010,
      ST_COMPARE = 4'b0100,
      ST_COPY    = 4'b1000
   } front_state_type;

   localparam int ROW_W  = dfdu_pkg::ROW_W;
   localparam int COL_W  = dfdu_pkg::COL_W;
   localparam int ADDR_W = dfdu_pkg::ADDR_W;
   localparam int WORD_W = dfdu_pkg::WORD_W;
   localparam int RC_W   = dfdu_pkg::RC_W;
   localparam int WPR_W  = dfdu_pkg::WPR_W;

   front_state_type   state_ff, state_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              run_open_ff, run_open_in;
   logic [COL_W-1:0]  first_ff, first_in;
   logic [COL_W-1:0]  last_ff, last_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [ROW_W-1:0]  send_row_ff, send_row_in;
   logic [COL_W-1:0]  send_last_ff, send_last_in;
   logic [COL_W-1:0]  copy_col_ff, copy_col_in;
   logic              hdr_pend_ff, hdr_pend_in;
   logic [COL_W-1:0]  send_first_ff, send_first_in;
   logic [WORD_W-1:0] buf_ff [dfdu_pkg::MAX_WORDS_PER_ROW];

   logic [RC_W-1:0]   rc_eff;
   logic [WPR_W-1:0]  wpr_eff;
   logic              accept;
   logic              row_wrap;
   logic [ROW_W-1:0]  row_eff;
   logic [COL_W-1:0]  col_eff;
   logic              open_eff;
   logic              changed;
   logic              row_end;
   logic              open_now;
   logic [COL_W-1:0]  first_now;
   logic [COL_W-1:0]  last_now;
   logic              send;
   logic [RC_W-1:0]   row_inc;
   logic [ROW_W-1:0]  row_next;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] rd_data;

   assign rc_eff  = (row_count == '0) ? RC_W'(1) :
                    ((row_count > dfdu_pkg::RC_MAX) ? dfdu_pkg::RC_MAX : row_count);
   assign wpr_eff = (words_per_row == '0) ? WPR_W'(1) :
                    ((words_per_row > dfdu_pkg::WPR_MAX) ? dfdu_pkg::WPR_MAX : words_per_row);

   assign full   = (state_ff != ST_IDLE);
   assign accept = push && (state_ff == ST_IDLE);

   assign row_wrap = ({1'b0, row_ff} >= rc_eff);
   assign row_eff  = (frame_start || row_wrap) ? '0 : row_ff;
   assign col_eff  = frame_start ? '0 : col_ff;
   assign open_eff = run_open_ff && !frame_start && !row_wrap;

   assign changed   = (rd_data != word_ff);
   assign row_end   = ({1'b0, col_ff} + WPR_W'(1)) >= wpr_eff;
   assign open_now  = run_open_ff || changed;
   assign first_now = (changed && !run_open_ff) ? col_ff : first_ff;
   assign last_now  = changed ? col_ff : last_ff;
   assign send      = (!changed && run_open_ff) || (row_end && open_now);
   assign row_inc   = {1'b0, row_ff} + RC_W'(1);
   assign row_next  = (row_inc >= rc_eff) ? '0 : row_inc[ROW_W-1:0];

   assign wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_COMPARE) && changed);
   assign wr_addr = (state_ff == ST_CLEAR) ? clear_addr_ff : {row_ff, col_ff};
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : word_ff;

   dfdu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (dfdu_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr ({row_eff, col_eff}),
      .rd_data (rd_data)
   );

   assign q_push = (state_ff == ST_COPY) && !q_full;

   always_comb begin
      q_entry = '0;
      if (hdr_pend_ff) begin
         q_entry.is_word = 1'b0;
         q_entry.last    = 1'b0;
         q_entry.word    = {dfdu_pkg::CMD_ADDR | {2'b00, send_row_ff},
                            dfdu_pkg::CMD_ADDR | {4'b0000, send_first_ff}};
      end else begin
         q_entry.is_word = 1'b1;
         q_entry.last    = (copy_col_ff == send_last_ff);
         q_entry.word    = dfdu_pkg::rev16(buf_ff[copy_col_ff]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      run_open_in   = run_open_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      word_in       = word_ff;
      send_row_in   = send_row_ff;
      send_first_in = send_first_ff;
      send_last_in  = send_last_ff;
      copy_col_in   = copy_col_ff;
      hdr_pend_in   = hdr_pend_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               row_in      = row_eff;
               col_in      = col_eff;
               run_open_in = open_eff;
               word_in     = pixel_word;
               state_in    = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            first_in      = first_now;
            last_in       = last_now;
            run_open_in   = open_now && !send;
            send_row_in   = row_ff;
            send_first_in = first_now;
            send_last_in  = last_now;
            copy_col_in   = first_now;
            hdr_pend_in   = 1'b1;
            if (row_end) begin
               col_in = '0;
               row_in = row_next;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
            state_in = send ? ST_COPY : ST_IDLE;
         end
         ST_COPY: begin
            if (!q_full) begin
               if (hdr_pend_ff) begin
                  hdr_pend_in = 1'b0;
               end else if (copy_col_ff == send_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  copy_col_in = copy_col_ff + COL_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         run_open_ff   <= 1'b0;
         first_ff      <= '0;
         last_ff       <= '0;
         hdr_pend_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         run_open_ff   <= run_open_in;
         first_ff      <= first_in;
         last_ff       <= last_in;
         hdr_pend_ff   <= hdr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      send_row_ff   <= send_row_in;
      send_first_ff <= send_first_in;
      send_last_ff  <= send_last_in;
      copy_col_ff   <= copy_col_in;
      if ((state_ff == ST_COMPARE) && changed) begin
         buf_ff[col_ff] <= word_ff;
      end
   end

endmodule

// File: src/dfdu_queue.sv
module dfdu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dfdu_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output dfdu_pkg::entry_type head,
   output logic                empty
);

   localparam int QPTR_W = dfdu_pkg::QPTR_W;
   localparam int CNT_W  = $clog2(dfdu_pkg::QUEUE_DEPTH + 1);

   dfdu_pkg::entry_type slot_ff [dfdu_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == CNT_W'(dfdu_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: src/dfdu_back.sv
module dfdu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  dfdu_pkg::entry_type         head,
   input  logic                        q_empty,
   output logic                        q_pop,
   output logic                        empty,
   input  logic                        pop,
   output logic [dfdu_pkg::BYTE_W-1:0] out_byte,
   output logic                        is_data,
   output logic                        last_byte
);

   localparam int BYTE_W = dfdu_pkg::BYTE_W;

   logic              phase_ff, phase_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              is_data_ff, is_data_in;
   logic              last_ff, last_in;
   logic              load;

   assign load  = !q_empty && (!valid_ff || pop);
   assign q_pop = load && phase_ff;

   always_comb begin
      phase_in   = phase_ff;
      valid_in   = valid_ff && !pop;
      byte_in    = byte_ff;
      is_data_in = is_data_ff;
      last_in    = last_ff;
      if (load) begin
         phase_in   = !phase_ff;
         valid_in   = 1'b1;
         byte_in    = phase_ff ? head.word[BYTE_W-1:0] : head.word[2*BYTE_W-1:BYTE_W];
         is_data_in = head.is_word;
         last_in    = head.last && phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      is_data_ff <= is_data_in;
      last_ff    <= last_in;
   end

   assign empty     = !valid_ff;
   assign out_byte  = byte_ff;
   assign is_data   = is_data_ff;
   assign last_byte = last_ff;

endmodule

// File: src/display_frame_diff_updater.sv
// Path: the word that closes a run goes to the compare state; the copy state writes the header
// into the queue and, when the queue is empty, the output register then shows its first byte.
// Flow: full is high while a word is compared and while a closing run is copied into the queue,
// so no new word is taken before the last is through; a full queue with pop held stalls the copy.
// Reset: synchronous; full stays high during a pass that zeroes every word of the frame copy.
// Registers return to 64 rows and 8 words per row and may be written during that pass.
module display_frame_diff_updater (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [dfdu_pkg::WORD_W-1:0]     req_pixel_word,
   input  logic                            req_frame_start,
   output logic                            empty,
   input  logic                            pop,
   output logic [dfdu_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                            rsp_is_data,
   output logic                            rsp_last_byte,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dfdu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dfdu_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [dfdu_pkg::RC_W-1:0]  row_count_ff, row_count_in;
   logic [dfdu_pkg::WPR_W-1:0] wpr_ff, wpr_in;
   logic                       q_full;
   logic                       q_push;
   logic                       q_empty;
   logic                       q_pop;
   dfdu_pkg::entry_type        q_entry;
   dfdu_pkg::entry_type        q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      row_count_in = row_count_ff;
      wpr_in       = wpr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dfdu_pkg::CSR_ROW_COUNT: begin
               row_count_in = csr_data[dfdu_pkg::RC_W-1:0];
            end
            dfdu_pkg::CSR_WORDS_PER_ROW: begin
               wpr_in = csr_data[dfdu_pkg::WPR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= dfdu_pkg::RC_RESET;
         wpr_ff       <= dfdu_pkg::WPR_RESET;
      end else begin
         row_count_ff <= row_count_in;
         wpr_ff       <= wpr_in;
      end
   end

   dfdu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .pixel_word    (req_pixel_word),
      .frame_start   (req_frame_start),
      .row_count     (row_count_ff),
      .words_per_row (wpr_ff),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   dfdu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   dfdu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .empty     (empty),
      .pop       (pop),
      .out_byte  (rsp_out_byte),
      .is_data   (rsp_is_data),
      .last_byte (rsp_last_byte)
   );

endmodule

// File: src/dfdu_checker.sv
`include "assert_macros.svh"

module dfdu_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        push,
   input logic                        full,
   input logic                        empty,
   input logic                        pop,
   input logic [dfdu_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                        rsp_is_data,
   input logic                        rsp_last_byte
);

   // clearing pass keeps input closed
   `ASSERT_CLK(a_full_after_reset, clock, reset |=> full)

   // every accepted word is looked up in the compare state
   `ASSERT_CLK_RST(a_full_after_accept, clock, reset, push && !full |=> full)

   `ASSERT_CLK_RST(a_cmd_has_addr_bit, clock, reset, !empty && !rsp_is_data |-> rsp_out_byte[7])

   `ASSERT_CLK_RST(a_cmd_not_last, clock, reset, !empty && !rsp_is_data |-> !rsp_last_byte)

   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, !empty && !pop |=> !empty && $stable(rsp_out_byte))

endmodule

bind display_frame_diff_updater dfdu_checker u_checker (.*);
